>>> design/fixed_point_alu_top_macros.svh
// Assertion macros used by the fixed-point ALU top level.
`ifndef FIXED_POINT_ALU_TOP_MACROS_SVH
`define FIXED_POINT_ALU_TOP_MACROS_SVH

`ifndef SYNTH
`define FPA_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fixed_point_alu check failed");
`define FPA_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed_point_alu implication failed");
`else
`define FPA_CHECK(lbl, cond)
`define FPA_IMPLY(lbl, ante, cons)
`endif

`endif

>>> design/fpa_pkg.sv
// Types, operation codes and helpers for the fixed-point ALU.
package fpa_pkg;

    localparam logic [3:0] KIND_ADD      = 4'd0;
    localparam logic [3:0] KIND_SUB      = 4'd1;
    localparam logic [3:0] KIND_MUL      = 4'd2;
    localparam logic [3:0] KIND_DIV      = 4'd3;
    localparam logic [3:0] KIND_INC      = 4'd4;
    localparam logic [3:0] KIND_DEC      = 4'd5;
    localparam logic [3:0] KIND_MIN      = 4'd6;
    localparam logic [3:0] KIND_MAX      = 4'd7;
    localparam logic [3:0] KIND_TO_INT   = 4'd8;
    localparam logic [3:0] KIND_FROM_INT = 4'd9;

    // widest dividend / quotient: 32 word bits plus 16 fraction bits
    localparam int DVD_MAX = 48;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               a_greater;
        logic               a_less;
        logic               a_equal;
        logic               overflowed;
        logic               divided_by_zero;
    } out_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic               gt;
        logic               lt;
        logic               eq;
        logic signed [31:0] res;
        logic               ovf;
        logic               dz;
        logic               neg;
        logic [63:0]        prod;
        logic [DVD_MAX-1:0] dvd;
        logic [31:0]        dsr;
        logic [31:0]        rem;
        logic [DVD_MAX-1:0] quo;
    } pipe_t;

    // saturate to a w-bit signed range; returns {ovf, value}
    function automatic logic [32:0] sat_word(input logic signed [63:0] v,
                                             input int unsigned w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            sat_word = {1'b1, hi[31:0]};
        else if (v < lo)
            sat_word = {1'b1, lo[31:0]};
        else
            sat_word = {1'b0, v[31:0]};
    endfunction

endpackage

>>> design/fixed_point_alu_top.sv
// Top level of the pipelined signed fixed-point ALU.
// Takes one beat per clock and returns one result beat per item, in order, through
// an entry stage that decodes the operands and multiplies, a chain of division
// cells that resolve one quotient bit each, and a result stage that rounds half
// away from zero and saturates. The chain runs for every item so all operations
// share the same latency. A stall on the result side holds the whole pipe; bubbles
// move forward while the output is free.
`include "fixed_point_alu_top_macros.svh"

module fixed_point_alu_top #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  fpa_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output fpa_pkg::out_t result
);

    localparam int W  = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 16) ? 16 : WORD_BITS);
    localparam int F  = (FRAC_BITS > 16) ? 16 : ((FRAC_BITS < 0) ? 0 : FRAC_BITS);
    localparam int QB = W + F;

    localparam logic signed [31:0] HI32 = 32'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [31:0] LO32 = -HI32 - 32'sd1;

    logic           adv;
    logic           stage_valid [QB+1];
    fpa_pkg::pipe_t stage_data  [QB+1];

    assign adv        = !result_valid || !result_stall;
    assign item_stall = !adv;

    fpa_prep #(.W(W), .F(F)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .src_valid (item_valid),
        .src       (item),
        .dst_valid (stage_valid[0]),
        .dst       (stage_data[0])
    );

    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        fpa_cell #(.BIT(QB - 1 - i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .src_valid (stage_valid[i]),
            .src       (stage_data[i]),
            .dst_valid (stage_valid[i+1]),
            .dst       (stage_data[i+1])
        );
    end

    fpa_out #(.W(W), .F(F)) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .src_valid (stage_valid[QB]),
        .src       (stage_data[QB]),
        .dst_valid (result_valid),
        .dst       (result)
    );

    `FPA_IMPLY(a_cmp_onehot, result_valid, $onehot({result.a_greater, result.a_less, result.a_equal}))
    `FPA_IMPLY(a_dz_zero, result_valid && result.divided_by_zero && !result.overflowed, result.value == 32'sd0)
    `FPA_IMPLY(a_ovf_bound, result_valid && result.overflowed, result.value == HI32 || result.value == LO32)
    `FPA_IMPLY(a_in_range, result_valid, result.value <= HI32 && result.value >= LO32)

endmodule

>>> design/fpa_prep.sv
// Entry stage: operand decode, simple operations, multiply and divider setup.
module fpa_prep #(
    parameter int W = 32,
    parameter int F = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          src_valid,
    input  fpa_pkg::in_t  src,
    output logic          dst_valid,
    output fpa_pkg::pipe_t dst
);

    localparam int SH = 32 - W;

    logic                valid_reg;
    fpa_pkg::pipe_t      data_reg;
    fpa_pkg::pipe_t      data_next;
    logic signed [31:0]  a;
    logic signed [31:0]  b;
    logic [31:0]         ma;
    logic [31:0]         mb;
    logic signed [63:0]  a64;
    logic signed [63:0]  b64;
    logic signed [63:0]  sum;
    logic [47:0]         shl;
    logic [32:0]         sat;
    logic signed [63:0]  hi;

    always_comb
    begin
        a   = (src.operand_a <<< SH) >>> SH;
        b   = (src.operand_b <<< SH) >>> SH;
        ma  = a[31] ? (32'd0 - a) : a;
        mb  = b[31] ? (32'd0 - b) : b;
        a64 = 64'(a);
        b64 = 64'(b);
        shl = 48'(ma) << F;
        hi  = (64'sd1 <<< (W - 1)) - 64'sd1;

        data_next      = '0;
        data_next.kind = src.kind;
        data_next.gt   = a > b;
        data_next.lt   = a < b;
        data_next.eq   = a == b;
        data_next.neg  = a[31] ^ b[31];
        data_next.prod = 64'(ma) * 64'(mb);
        data_next.dvd  = shl;
        data_next.dsr  = mb;
        data_next.dz   = (src.kind == fpa_pkg::KIND_DIV) && (b == 32'sd0);

        unique case (src.kind)
            fpa_pkg::KIND_ADD:     sum = a64 + b64;
            fpa_pkg::KIND_SUB:     sum = a64 - b64;
            fpa_pkg::KIND_INC:     sum = a64 + 64'sd1;
            fpa_pkg::KIND_DEC:     sum = a64 - 64'sd1;
            fpa_pkg::KIND_MIN:     sum = (a < b) ? a64 : b64;
            fpa_pkg::KIND_MAX:     sum = (a > b) ? a64 : b64;
            fpa_pkg::KIND_TO_INT:  sum = a64 >>> F;
            fpa_pkg::KIND_FROM_INT:
                sum = a[31] ? -$signed({16'd0, shl}) : $signed({16'd0, shl});
            // zero divisor: push a nonzero dividend just past the bound so saturation flags it; zero gives zero
            fpa_pkg::KIND_DIV:
                sum = (a > 32'sd0) ? hi + 64'sd1
                                   : ((a < 32'sd0) ? -hi - 64'sd2 : 64'sd0);
            default:               sum = 64'sd0;
        endcase

        sat           = fpa_pkg::sat_word(sum, W);
        data_next.res = sat[31:0];
        data_next.ovf = sat[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign dst_valid = valid_reg;
    assign dst       = data_reg;

endmodule

>>> design/fpa_cell.sv
// One restoring-division cell: resolves one quotient bit per beat.
module fpa_cell #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           src_valid,
    input  fpa_pkg::pipe_t src,
    output logic           dst_valid,
    output fpa_pkg::pipe_t dst
);

    logic           valid_reg;
    fpa_pkg::pipe_t data_reg;
    fpa_pkg::pipe_t data_next;
    logic [32:0]    trial;
    logic           fits;

    always_comb
    begin
        trial     = {src.rem, src.dvd[BIT]};
        fits      = trial >= {1'b0, src.dsr};
        data_next = src;
        data_next.rem = fits ? 32'(trial - {1'b0, src.dsr}) : trial[31:0];
        data_next.quo = {src.quo[fpa_pkg::DVD_MAX-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign dst_valid = valid_reg;
    assign dst       = data_reg;

endmodule

>>> design/fpa_out.sv
// Result stage: rounding of multiply and divide, saturation, output register.
module fpa_out #(
    parameter int W = 32,
    parameter int F = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           src_valid,
    input  fpa_pkg::pipe_t src,
    output logic           dst_valid,
    output fpa_pkg::out_t  dst
);

    logic               valid_reg;
    fpa_pkg::out_t      data_reg;
    fpa_pkg::out_t      data_next;
    logic [63:0]        half;
    logic [63:0]        q;
    logic               rnd;
    logic signed [63:0] sv;
    logic [32:0]        sat;

    always_comb
    begin
        half = (F > 0) ? (64'd1 << (F - 1)) : 64'd0;
        rnd  = {src.rem, 1'b0} >= {1'b0, src.dsr};
        if (src.kind == fpa_pkg::KIND_MUL)
            q = (src.prod + half) >> F;
        else
            q = 64'(src.quo) + 64'(rnd);
        sv  = src.neg ? -$signed(q) : $signed(q);
        sat = fpa_pkg::sat_word(sv, W);

        data_next                 = '0;
        data_next.a_greater       = src.gt;
        data_next.a_less          = src.lt;
        data_next.a_equal         = src.eq;
        data_next.divided_by_zero = src.dz;
        if ((src.kind == fpa_pkg::KIND_MUL) ||
            ((src.kind == fpa_pkg::KIND_DIV) && !src.dz))
        begin
            data_next.value      = sat[31:0];
            data_next.overflowed = sat[32];
        end
        else
        begin
            data_next.value      = src.res;
            data_next.overflowed = src.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign dst_valid = valid_reg;
    assign dst       = data_reg;

endmodule
